[sv/sincos_pkg.sv]
// shared types, constants and arithmetic helpers for the sine/cosine unit
package sincos_pkg;

  // default formats of the angle and the result
  localparam int ANGLE_FRAC_BITS_DEF  = 24;
  localparam int RESULT_FRAC_BITS_DEF = 30;

  // internal widths
  localparam int WIDE_W    = 56;  // signed angle scaled to 32 fraction bits
  localparam int REM_W     = 35;  // remainder modulo 2pi
  localparam int RED_STEPS = 19;  // one conditional subtract of 2pi*2^k per stage
  localparam int HORNER_N  = 5;

  typedef logic [REM_W-1:0] rem_t;

  // constants with 32 fraction bits
  localparam logic [REM_W-1:0] Q_PI         = 35'h3243F6A89;
  localparam logic [REM_W-1:0] Q_HALF_PI    = 35'h1921FB544;
  localparam logic [REM_W-1:0] Q_QUARTER_PI = 35'h0C90FDAA2;
  localparam logic [REM_W-1:0] Q_TWO_PI     = 35'h6487ED512;
  // multiple of 2pi that lifts any scaled angle above zero
  localparam logic [WIDE_W-1:0] Q_OFFSET    = WIDE_W'(Q_TWO_PI) << (RED_STEPS - 2);

  localparam logic [63:0] Q_ONE = 64'h1_0000_0000;
  localparam logic [63:0] R2  = (Q_ONE + 64'd2 / 2) / 64'd2;
  localparam logic [63:0] R3  = (Q_ONE + 64'd6 / 2) / 64'd6;
  localparam logic [63:0] R4  = (Q_ONE + 64'd24 / 2) / 64'd24;
  localparam logic [63:0] R5  = (Q_ONE + 64'd120 / 2) / 64'd120;
  localparam logic [63:0] R6  = (Q_ONE + 64'd720 / 2) / 64'd720;
  localparam logic [63:0] R7  = (Q_ONE + 64'd5040 / 2) / 64'd5040;
  localparam logic [63:0] R8  = (Q_ONE + 64'd40320 / 2) / 64'd40320;
  localparam logic [63:0] R9  = (Q_ONE + 64'd362880 / 2) / 64'd362880;
  localparam logic [63:0] R10 = (Q_ONE + 64'd3628800 / 2) / 64'd3628800;
  localparam logic [63:0] R11 = (Q_ONE + 64'd39916800 / 2) / 64'd39916800;

  // per-stage data in the polynomial pipeline
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] x2;
    logic [32:0] t;
    logic        neg;
    logic        cosf;
  } bk_t;

  // rounded product with 32 fraction bits
  function automatic logic [32:0] qmul(input logic [31:0] a, input logic [32:0] b);
    logic [64:0] p;
    p = 65'(a) * 65'(b) + 65'h0_8000_0000;
    return p[64:32];
  endfunction

  // horner coefficient by step, sine or cosine series
  function automatic logic [32:0] coef(input logic cosf, input logic [2:0] idx);
    logic [63:0] c;
    case (idx)
      3'd0:    c = cosf ? R10 : R11;
      3'd1:    c = cosf ? R8  : R9;
      3'd2:    c = cosf ? R6  : R7;
      3'd3:    c = cosf ? R4  : R5;
      3'd4:    c = cosf ? R2  : R3;
      default: c = Q_ONE;
    endcase
    return c[32:0];
  endfunction

endpackage

[sv/sincos_front.sv]
// front part: scales the angle, applies the cosine shift and reduces modulo 2pi
module sincos_front #(
  parameter int ANGLE_FRAC_BITS = sincos_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       angle,
  input  logic              mode,
  output logic              rem_valid,
  input  logic              rem_ready,
  output sincos_pkg::rem_t  rem
);
  import sincos_pkg::*;

  localparam int SHIFT = 32 - ANGLE_FRAC_BITS;

  logic [RED_STEPS:0]  v_r;
  logic [WIDE_W-1:0]   u_r   [RED_STEPS+1];
  logic [WIDE_W-1:0]   u_nxt [RED_STEPS+1];
  logic                en;

  // whole pipeline holds while the last stage cannot hand off
  assign en        = !(v_r[RED_STEPS] && !rem_ready);
  assign in_tready = en;
  assign rem_valid = v_r[RED_STEPS];
  assign rem       = u_r[RED_STEPS][REM_W-1:0];

  // scale to 32 fraction bits, shift for cosine, lift above zero
  always_comb begin
    logic signed [WIDE_W-1:0] a;
    a = signed'({{(WIDE_W-32){angle[31]}}, angle}) <<< SHIFT;
    if (mode) begin
      a = signed'(WIDE_W'(Q_HALF_PI)) - a;
    end
    u_nxt[0] = unsigned'(a) + Q_OFFSET;
  end

  // one conditional subtract of 2pi*2^k per stage, largest first
  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    localparam logic [WIDE_W-1:0] M = WIDE_W'(Q_TWO_PI) << (RED_STEPS - 1 - j);
    always_comb begin
      u_nxt[j+1] = (u_r[j] >= M) ? u_r[j] - M : u_r[j];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[RED_STEPS-1:0], in_tvalid};
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= RED_STEPS; i++) begin
        u_r[i] <= u_nxt[i];
      end
    end
  end

endmodule

[sv/sincos_fifo.sv]
// short queue of reduced angles between the front and back parts
module sincos_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  sincos_pkg::rem_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sincos_pkg::rem_t pop_data
);
  import sincos_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  rem_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push, pop;

  assign push_ready = (cnt_r != (AW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and count update
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

[sv/sincos_back.sv]
// back part: folds the reduced angle, evaluates the polynomial, rounds and applies the sign
module sincos_back #(
  parameter int RESULT_FRAC_BITS = sincos_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rem_valid,
  output logic             rem_ready,
  input  sincos_pkg::rem_t rem,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      value
);
  import sincos_pkg::*;

  localparam int NST = HORNER_N + 3;  // fold, square, horner steps, magnitude

  logic [NST:0]  v_r;
  bk_t           s_r   [NST];
  bk_t           s_nxt [NST];
  logic [31:0]   value_r, value_nxt;
  logic          en;

  assign en         = !v_r[NST] || out_tready;
  assign rem_ready  = en;
  assign out_tvalid = v_r[NST];
  assign value      = value_r;

  // fold to the first quadrant and pick the series
  always_comb begin
    logic [REM_W-1:0] r1, r2;
    s_nxt[0]      = '0;
    s_nxt[0].neg  = rem > Q_PI;
    r1            = s_nxt[0].neg ? rem - Q_PI : rem;
    r2            = (r1 > Q_HALF_PI) ? Q_PI - r1 : r1;
    s_nxt[0].cosf = r2 > Q_QUARTER_PI;
    r1            = s_nxt[0].cosf ? Q_HALF_PI - r2 : r2;
    s_nxt[0].x    = r1[31:0];
  end

  // square and first coefficient
  always_comb begin
    logic [32:0] sq;
    sq         = qmul(s_r[0].x, {1'b0, s_r[0].x});
    s_nxt[1]   = s_r[0];
    s_nxt[1].x2 = sq[31:0];
    s_nxt[1].t = coef(s_r[0].cosf, 3'd0);
  end

  // horner steps
  for (genvar h = 0; h < HORNER_N; h++) begin : g_horner
    always_comb begin
      s_nxt[h+2]   = s_r[h+1];
      s_nxt[h+2].t = coef(s_r[h+1].cosf, 3'(h + 1)) - qmul(s_r[h+1].x2, s_r[h+1].t);
    end
  end

  // odd series takes a last factor of x
  always_comb begin
    s_nxt[NST-1]   = s_r[NST-2];
    s_nxt[NST-1].t = s_r[NST-2].cosf ? s_r[NST-2].t : qmul(s_r[NST-2].x, s_r[NST-2].t);
  end

  // round to the result format and apply the sign
  always_comb begin
    logic [33:0] sum;
    logic [31:0] mag;
    sum = {1'b0, s_r[NST-1].t} + (34'd1 << (31 - RESULT_FRAC_BITS));
    mag = 32'(sum >> (32 - RESULT_FRAC_BITS));
    value_nxt = s_r[NST-1].neg ? 32'd0 - mag : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-1:0], rem_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        s_r[i] <= s_nxt[i];
      end
      value_r <= value_nxt;
    end
  end

endmodule

[sv/sine_cosine_polynomial.sv]
// sine/cosine unit: angle reduction front, queue, polynomial back
// throughput: one request per cycle while the output is not stalled by out_tready;
// the reduction and polynomial pipelines each take a new item every cycle, with a
// 4-entry queue between them
// reset: synchronous active-low rst_n clears all valid bits and the queue
module sine_cosine_polynomial #(
  parameter int ANGLE_FRAC_BITS  = sincos_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = sincos_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // angle [31:0]
  input  logic        in_tuser,   // mode [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // value [31:0]
);
  import sincos_pkg::*;

  logic fr_valid, fr_ready, bk_valid, bk_ready;
  rem_t fr_rem, bk_rem;

  // angle reduction
  sincos_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .angle     (in_tdata),
    .mode      (in_tuser),
    .rem_valid (fr_valid),
    .rem_ready (fr_ready),
    .rem       (fr_rem)
  );

  // decoupling queue
  sincos_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_rem),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_rem)
  );

  // polynomial evaluation
  sincos_back #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rem_valid  (bk_valid),
    .rem_ready  (bk_ready),
    .rem        (bk_rem),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .value      (out_tdata)
  );

endmodule

[tb/sv/sine_cosine_polynomial_tb.sv]
// testbench for the sine/cosine unit: directed and random requests vs a fixed-point predictor
module sine_cosine_polynomial_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_FRAC  = 24;
  localparam int RESULT_FRAC = 30;
  localparam int LATENCY     = 30;
  localparam int WATCHDOG    = 5000;
  localparam logic MODE_SINE   = 1'b0;
  localparam logic MODE_COSINE = 1'b1;

  // constants with 32 fraction bits
  localparam longint K_PI      = 64'sh3243F6A89;
  localparam longint K_HALF_PI = 64'sh1921FB544;
  localparam longint K_QTR_PI  = 64'shC90FDAA2;
  localparam longint K_TWO_PI  = 2 * K_PI;
  localparam longint unsigned K_ONE = 64'h1_0000_0000;

  typedef struct packed {
    logic [31:0] angle;
    logic        mode;
  } angle_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  angle_req_t  pending_reqs[$];
  logic [31:0] expected_values[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_sender;
  bit          timed_out;
  bit          in_taken;
  int          mismatches;
  int          quiet_cycles;

  sine_cosine_polynomial uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // rounded 1/n! with 32 fraction bits
  function automatic longint unsigned inv_fact(input longint unsigned f);
    return (K_ONE + f / 2) / f;
  endfunction

  function automatic longint unsigned fix_mul(input longint unsigned a, input longint unsigned b);
    return (a * b + 64'h8000_0000) >> 32;
  endfunction

  function automatic longint unsigned sine_series(input longint unsigned x);
    longint unsigned x2, t;
    x2 = fix_mul(x, x);
    t = inv_fact(39916800);
    t = inv_fact(362880) - fix_mul(x2, t);
    t = inv_fact(5040) - fix_mul(x2, t);
    t = inv_fact(120) - fix_mul(x2, t);
    t = inv_fact(6) - fix_mul(x2, t);
    t = K_ONE - fix_mul(x2, t);
    return fix_mul(x, t);
  endfunction

  function automatic longint unsigned cosine_series(input longint unsigned x);
    longint unsigned x2, t;
    x2 = fix_mul(x, x);
    t = inv_fact(3628800);
    t = inv_fact(40320) - fix_mul(x2, t);
    t = inv_fact(720) - fix_mul(x2, t);
    t = inv_fact(24) - fix_mul(x2, t);
    t = inv_fact(2) - fix_mul(x2, t);
    return K_ONE - fix_mul(x2, t);
  endfunction

  // expected sine or cosine for one request
  function automatic logic [31:0] predict_value(input angle_req_t req);
    longint a, q, r;
    longint unsigned mag, rounded;
    bit neg;
    a = longint'(signed'(req.angle)) * (longint'(1) << (32 - ANGLE_FRAC));
    if (req.mode == MODE_COSINE) a = K_HALF_PI - a;
    q = a / K_TWO_PI;
    r = a - q * K_TWO_PI;
    if (r < 0) r += K_TWO_PI;
    neg = 0;
    if (r > K_PI) begin
      neg = 1;
      r -= K_PI;
    end
    if (r > K_HALF_PI) r = K_PI - r;
    if (r > K_QTR_PI) mag = cosine_series(longint'(K_HALF_PI - r));
    else mag = sine_series(r);
    rounded = (mag + (64'd1 << (31 - RESULT_FRAC))) >> (32 - RESULT_FRAC);
    if (neg) rounded = 64'd0 - rounded;
    return rounded[31:0];
  endfunction

  function automatic angle_req_t make_req(input logic [31:0] angle, input logic mode);
    angle_req_t req;
    req.angle = angle;
    req.mode = mode;
    return req;
  endfunction

  // append one request to the pending queue
  task automatic enqueue_req(input angle_req_t req);
    pending_reqs = {pending_reqs, req};
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: change inputs at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (!in_tvalid || in_taken) begin
        if (pending_reqs.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          angle_req_t req;
          req = pending_reqs.pop_front();
          in_tvalid <= 1;
          in_tdata  <= req.angle;
          in_tuser  <= req.mode;
        end else begin
          in_tvalid <= 0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: record accepted requests and compare each result at the rising edge
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_values = {expected_values, predict_value(make_req(in_tdata, in_tuser))};
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_tvalid && out_tready) begin
        if (expected_values.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          logic [31:0] want;
          want = expected_values.pop_front();
          if (want !== out_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("value mismatch: expected %h actual %h", want, out_tdata);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst_n && quiet_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_values.size() > 0)
      @(posedge clk);
  endtask

  // random angle, biased toward multiples of pi/2 and small magnitudes
  function automatic angle_req_t random_req();
    logic [31:0] angle;
    longint base;
    case ($urandom_range(3))
      0: angle = $urandom;
      1: angle = $urandom_range(65535) - 32768;
      default: begin
        base = (K_HALF_PI * $urandom_range(100)) >>> (32 - ANGLE_FRAC);
        angle = 32'(base - 2 * $urandom_range(1)* base + $urandom_range(4) - 2);
      end
    endcase
    return make_req(angle, logic'($urandom_range(1)));
  endfunction

  task automatic fill_random(input int n);
    repeat (n) enqueue_req(random_req());
  endtask

  initial begin
    longint two_pi_a;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    out_tready = 0;
    send_idle_pct = 13;
    recv_idle_pct = 52;
    hold_sender = 0;
    timed_out = 0;
    in_taken = 0;
    mismatches = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: field extremes, both modes, quadrant edges, negative multiples of 2pi
    two_pi_a = K_TWO_PI >>> (32 - ANGLE_FRAC);
    for (int m = 0; m < 2; m++) begin
      enqueue_req(make_req(32'h0000_0000, logic'(m)));
      enqueue_req(make_req(32'h7FFF_FFFF, logic'(m)));
      enqueue_req(make_req(32'h8000_0000, logic'(m)));
      enqueue_req(make_req(32'hFFFF_FFFF, logic'(m)));
      enqueue_req(make_req(32'h0000_0001, logic'(m)));
      enqueue_req(make_req(32'(K_QTR_PI >>> 8), logic'(m)));
      enqueue_req(make_req(32'(K_HALF_PI >>> 8), logic'(m)));
      enqueue_req(make_req(32'(K_PI >>> 8), logic'(m)));
      enqueue_req(make_req(32'(-two_pi_a), logic'(m)));
      enqueue_req(make_req(32'(-3 * two_pi_a), logic'(m)));
      enqueue_req(make_req(32'hAAAA_AAAA, logic'(m)));
    end
    enqueue_req(make_req(32'h5555_5555, MODE_SINE));
    enqueue_req(make_req(32'h5555_5555, MODE_COSINE));
    fill_random(130);
    wait_drained();

    // sender holds off until the pipeline is empty
    hold_sender = 1;
    repeat (LATENCY + 5) @(posedge clk);
    hold_sender = 0;

    send_idle_pct = 52;
    recv_idle_pct = 13;
    fill_random(130);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(130);
    wait_drained();

    repeat (LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
